// ===== rtl/assert_macros.svh =====
// assertion macros used by fixed_point_alu_unit
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/fpalu_pkg.sv =====
// types, opcodes and constants for the fixed-point alu
// no dependencies
package fpalu_pkg;

    localparam int FracBitsDefault = 8;
    localparam int DataW = 32;
    // divider cells: one quotient bit per cell over a 64-bit scaled dividend
    localparam int DivW = 64;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_LT = 4'd4, OP_GT = 4'd5, OP_LE = 4'd6, OP_GE = 4'd7,
        OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
    } t_op;

    typedef struct packed {
        logic [3:0]        op;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               overflow;
        logic               divide_by_zero;
    } t_out_item;

    // one item travelling along the cell chain
    typedef struct packed {
        logic               vld;
        t_out_item          res;      // finished result for non-divide ops
        logic               is_div;
        logic               q_neg;    // quotient sign
        logic [DivW-1:0]    rem;      // partial remainder
        logic [DivW-1:0]    quo;      // dividend bits shifting into quotient
        logic [DataW-1:0]   divisor;  // magnitude of divisor
    } t_cell_data;

endpackage

// ===== rtl/fpalu_front.sv =====
// front stage: decode, add/sub/compare/min/max/inc/dec/convert ops, registered multiply, divide setup
// depends on fpalu_pkg
module fpalu_front
    import fpalu_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_vld,
    input  t_in_item   i_item,
    output t_cell_data o_data
);

    logic signed [32:0] a33, b33, sum, dif, inc, dec;
    logic signed [63:0] prod, shl, mres, dabs;
    logic               lt, eq;
    t_cell_data         n_d, r_d;
    logic signed [63:0] r_prod;
    logic               r_mul;

    // full-precision arithmetic and decode for every op
    always_comb begin
        a33  = 33'(i_item.operand_a);
        b33  = 33'(i_item.operand_b);
        sum  = a33 + b33;
        dif  = a33 - b33;
        inc  = a33 + (33'sd1 <<< FRAC_BITS);
        dec  = a33 - (33'sd1 <<< FRAC_BITS);
        lt   = i_item.operand_a < i_item.operand_b;
        eq   = i_item.operand_a == i_item.operand_b;
        shl  = 64'(i_item.operand_a) <<< FRAC_BITS;
        dabs = shl[63] ? -shl : shl;
        n_d  = '0;
        n_d.vld = i_vld;
        unique case (t_op'(i_item.op))
            OP_ADD: begin
                n_d.res.result_value = sum[31:0];
                n_d.res.overflow = sum[32] != sum[31];
            end
            OP_SUB: begin
                n_d.res.result_value = dif[31:0];
                n_d.res.overflow = dif[32] != dif[31];
            end
            OP_MUL: ;
            OP_DIV: begin
                n_d.is_div = 1'b1;
                n_d.q_neg = i_item.operand_a[31] ^ i_item.operand_b[31];
                n_d.quo = dabs;
                n_d.divisor = i_item.operand_b[31] ? 32'(-i_item.operand_b)
                                                   : i_item.operand_b;
                n_d.res.divide_by_zero = i_item.operand_b == '0;
            end
            OP_LT: n_d.res.compare_true = lt;
            OP_GT: n_d.res.compare_true = !lt && !eq;
            OP_LE: n_d.res.compare_true = lt || eq;
            OP_GE: n_d.res.compare_true = !lt;
            OP_EQ: n_d.res.compare_true = eq;
            OP_NE: n_d.res.compare_true = !eq;
            OP_MIN: n_d.res.result_value = lt ? i_item.operand_a : i_item.operand_b;
            OP_MAX: n_d.res.result_value = (!lt && !eq) ? i_item.operand_a
                                                         : i_item.operand_b;
            OP_INC: begin
                n_d.res.result_value = inc[31:0];
                n_d.res.overflow = inc[32] != inc[31];
            end
            OP_DEC: begin
                n_d.res.result_value = dec[31:0];
                n_d.res.overflow = dec[32] != dec[31];
            end
            OP_FROM_INT: begin
                n_d.res.result_value = shl[31:0];
                n_d.res.overflow = shl[63:31] != {33{shl[31]}};
            end
            OP_TO_INT: n_d.res.result_value = i_item.operand_a >>> FRAC_BITS;
            default: ;
        endcase
    end

    // stage registers, product registered before the shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d    <= n_d;
            r_prod <= 64'(i_item.operand_a) * 64'(i_item.operand_b);
            r_mul  <= t_op'(i_item.op) == OP_MUL;
        end
    end

    // apply product shift and overflow on the registered product
    always_comb begin
        prod = r_prod;
        mres = prod >>> FRAC_BITS;
        o_data = r_d;
        if (r_mul) begin
            o_data.res.result_value = mres[31:0];
            o_data.res.overflow = mres[63:31] != {33{mres[31]}};
        end
    end

endmodule

// ===== rtl/fpalu_div_cell.sv =====
// one restoring-division cell: retires one quotient bit and passes the item on
// depends on fpalu_pkg
module fpalu_div_cell
    import fpalu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_cell_data i_data,
    output t_cell_data o_data
);

    t_cell_data        n_d, r_d;
    logic [DivW:0]     trial;
    logic [DivW-1:0]   rsh;

    // shift in next dividend bit and try a subtract
    always_comb begin
        n_d   = i_data;
        rsh   = {i_data.rem[DivW-2:0], i_data.quo[DivW-1]};
        trial = {1'b0, rsh} - {{(DivW-DataW+1){1'b0}}, i_data.divisor};
        if (i_data.is_div) begin
            n_d.rem = trial[DivW] ? rsh : trial[DivW-1:0];
            n_d.quo = {i_data.quo[DivW-2:0], !trial[DivW]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_data = r_d;

endmodule

// ===== rtl/fixed_point_alu_unit.sv =====
// Signed 32-bit fixed-point alu, FRAC_BITS fraction bits.
// Input channel: i_in_valid / o_in_ready carry op, operand_a, operand_b.
// Output channel: o_out_valid / i_out_ready carry result_value and the
// compare_true, overflow and divide_by_zero flags.
// One item may enter every cycle unless the receiver stalls. Every item,
// whatever its op, walks the same pipe: one front stage (decode,
// add/compare, 32x32 multiply), then a chain of 64 divider cells, each
// retiring one quotient bit, then a final stage that applies quotient
// sign and overflow. Throughput is one item a cycle while the receiver
// does not stall.
// When the receiver stalls the whole pipe holds in place: o_in_ready drops
// while the output register holds an item and i_out_ready is low, so no item
// is lost or repeated.
// Reset clears all valid bits; the pipe is empty afterwards.
// Depends on fpalu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fixed_point_alu_unit
    import fpalu_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_cell_data chain [DivW+1];
    logic       en;
    t_out_item  n_out, r_out;
    logic       r_vld;
    logic [DivW-1:0] q;
    logic [DivW:0]   qs;

    // pipe advances unless the output register holds an untaken item
    assign en = !r_vld || i_out_ready;
    assign o_in_ready = en;

    fpalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(i_in_valid), .i_item(i_in_item), .o_data(chain[0])
    );

    // row of divider cells
    for (genvar g = 0; g < DivW; g++) begin : g_cell
        fpalu_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_data(chain[g]), .o_data(chain[g+1])
        );
    end

    // final sign, overflow and zero-divisor handling
    always_comb begin
        n_out = chain[DivW].res;
        q  = chain[DivW].quo;
        qs = chain[DivW].q_neg ? -{1'b0, q} : {1'b0, q};
        if (chain[DivW].is_div) begin
            if (chain[DivW].res.divide_by_zero) begin
                n_out.result_value = '0;
                n_out.overflow = 1'b0;
            end else begin
                n_out.result_value = qs[31:0];
                n_out.overflow = qs[DivW:31] != {(DivW-30){qs[31]}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= chain[DivW].vld;
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vld;
    assign o_out_item  = r_out;

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_IMPLY(a_ready, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    `ASSERT_IMPLY(a_dz_flags, i_clk, i_rst_n, o_out_valid && o_out_item.divide_by_zero,
        !o_out_item.overflow && o_out_item.result_value == '0)

endmodule

// ===== tb/sv/tb_fixed_point_alu_unit.sv =====
// testbench for fixed_point_alu_unit: directed and random items checked
// against a local predictor of the fixed-point alu
// depends on fpalu_pkg and the fixed_point_alu_unit rtl
module tb_fixed_point_alu_unit;
    import fpalu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 8;
    localparam int PIPE_LATENCY = 66;
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    t_out_item expected_results[$];
    int        error_count;
    int        cycle_count;
    int        burst_left;
    logic      stall_random;

    fixed_point_alu_unit #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // predict the result of one item
    function automatic t_out_item alu_predict(t_in_item it);
        t_out_item        r;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] v;
        logic signed [63:0] one;
        logic             chk;
        a = 64'(it.operand_a);
        b = 64'(it.operand_b);
        one = 64'sd1 <<< FRAC;
        r = '0;
        v = 0;
        chk = 1'b0;
        case (t_op'(it.op))
            OP_ADD: begin v = a + b; chk = 1'b1; end
            OP_SUB: begin v = a - b; chk = 1'b1; end
            OP_MUL: begin v = (a * b) >>> FRAC; chk = 1'b1; end
            OP_DIV: begin
                if (b == 0) r.divide_by_zero = 1'b1;
                else begin v = (a * one) / b; chk = 1'b1; end
            end
            OP_LT: r.compare_true = a < b;
            OP_GT: r.compare_true = a > b;
            OP_LE: r.compare_true = a <= b;
            OP_GE: r.compare_true = a >= b;
            OP_EQ: r.compare_true = a == b;
            OP_NE: r.compare_true = a != b;
            OP_MIN: v = (a < b) ? a : b;
            OP_MAX: v = (a > b) ? a : b;
            OP_INC: begin v = a + one; chk = 1'b1; end
            OP_DEC: begin v = a - one; chk = 1'b1; end
            OP_FROM_INT: begin v = a * one; chk = 1'b1; end
            default: v = a >>> FRAC;
        endcase
        r.result_value = v[31:0];
        r.overflow = chk && (v < -64'sd2147483648 || v > 64'sd2147483647);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    // send one item, with bursts and gaps; valid stays high inside a burst
    task automatic send_item(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        int       gap;
        t_in_item it;
        it.op = op;
        it.operand_a = a;
        it.operand_b = b;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(alu_predict(it));
        @(negedge i_clk);
    endtask

    // drop valid and wait until every expected item has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    // receiver stall pattern: stretches of always ready, stretches of random stalls
    always @(negedge i_clk) begin
        if (cycle_count % 300 == 0) stall_random <= $urandom_range(0, 1);
        i_out_ready <= stall_random ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    // result checker
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", o_out_item.result_value, 32'h0);
            end else begin
                t_out_item w;
                w = expected_results.pop_front();
                if (o_out_item.result_value !== w.result_value)
                    report_mismatch("result_value", o_out_item.result_value, w.result_value);
                if (o_out_item.compare_true !== w.compare_true)
                    report_mismatch("compare_true", 32'(o_out_item.compare_true),
                                    32'(w.compare_true));
                if (o_out_item.overflow !== w.overflow)
                    report_mismatch("overflow", 32'(o_out_item.overflow), 32'(w.overflow));
                if (o_out_item.divide_by_zero !== w.divide_by_zero)
                    report_mismatch("divide_by_zero", 32'(o_out_item.divide_by_zero),
                                    32'(w.divide_by_zero));
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // every op on extreme operands
    task automatic test_directed();
        logic [31:0] ext[6];
        ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'hffff_ff00};
        for (int op = 0; op < 16; op++)
            send_item(4'(op), ext[op % 6], ext[(op + 1) % 6]);
        send_item(OP_DIV, 32'h1234, 32'h0);
        send_item(OP_DIV, 32'h8000_0000, 32'hffff_ff00);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_MUL, 32'hffff_ffff, 32'h1);
        send_item(OP_INC, 32'h7fff_ffff, 32'h0);
        send_item(OP_DEC, 32'h8000_0000, 32'h0);
        send_item(OP_FROM_INT, 32'h0080_0000, 32'h0);
        send_item(OP_TO_INT, 32'hffff_ff01, 32'h0);
        send_item(OP_EQ, 32'h55, 32'h55);
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
            1: return 32'($signed($urandom_range(0, 2048)) - 1024);
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // random items
    task automatic test_random(int count);
        logic [31:0] a;
        for (int i = 0; i < count; i++) begin
            a = random_operand();
            send_item(4'($urandom_range(0, 15)), a,
                      ($urandom_range(0, 7) == 0) ? a : random_operand());
        end
    endtask

    // sender waits for a fully drained pipe mid-run
    task automatic test_drain_pause();
        test_random(600);
        wait_drained();
        test_random(600);
    endtask

    initial begin
        logic failed;
        error_count = 0;
        cycle_count = 0;
        burst_left = 0;
        stall_random = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_ready = 1'b1;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_drain_pause();
        wait_drained();
        repeat (PIPE_LATENCY + 10) @(negedge i_clk);
        failed = (error_count != 0) || (expected_results.size() != 0);
        if (!failed) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/fpalu_pkg.sv
rtl/fpalu_front.sv
rtl/fpalu_div_cell.sv
rtl/fixed_point_alu_unit.sv
tb/sv/tb_fixed_point_alu_unit.sv
